FILE: hw/rtl/pgm_hp_pkg.sv
`default_nettype none

package pgm_hp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_P       = 3'd1,
    PH_FIVE    = 3'd2,
    PH_LF      = 3'd3,
    PH_COMMENT = 3'd4,
    PH_WIDTH   = 3'd5,
    PH_HEIGHT  = 3'd6,
    PH_GRAY    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    NS_BLANKS = 2'd0,
    NS_SIGN   = 2'd1,
    NS_DIGITS = 2'd2,
    NS_DONE   = 2'd3
  } num_state_e;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_P         = 3'd1;
  localparam logic [2:0] ST_NO_FIVE      = 3'd2;
  localparam logic [2:0] ST_NO_LF        = 3'd3;
  localparam logic [2:0] ST_COMMENT_LONG = 3'd4;
  localparam logic [2:0] ST_WIDTH_LONG   = 3'd5;
  localparam logic [2:0] ST_HEIGHT_LONG  = 3'd6;
  localparam logic [2:0] ST_GRAY_LONG    = 3'd7;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0]  COMMENT_LIMIT = 8'd32;
  localparam logic [6:0]  WIDTH_LIMIT   = 7'd32;
  localparam logic [6:0]  HEIGHT_LIMIT  = 7'd64;
  localparam logic [6:0]  GRAY_LIMIT    = 7'd32;
  localparam logic [15:0] VALUE_MAX     = 16'hFFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/pgm_header_parser_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    header_byte_i, start_new_i
// result    out        out_valid_o / out_stall_i  status_o, width_o, height_o, gray_max_o,
//                                                 hdr_len_o, data_word_offset_o,
//                                                 data_byte_offset_o
//
// One header byte is taken per cycle unless stalled; any result shows in the next cycle.
// The only throughput limit is the single result register: a byte is held off
// only while a finished result waits and the result side stalls.
// After reset the parser is idle and ignores bytes until one carries start_new.
// A result stays on the ports unchanged for as long as it is stalled.
`default_nettype none

module pgm_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte_i,
  input  logic        start_new_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] width_o,
  output logic [15:0] height_o,
  output logic [15:0] gray_max_o,
  output logic [7:0]  hdr_len_o,
  output logic [5:0]  data_word_offset_o,
  output logic [1:0]  data_byte_offset_o
);
  import pgm_hp_pkg::*;

  phase_e     phase_q, phase_d, phase_cur;
  num_state_e ns_q, ns_d, ns_cur, ns_f;
  logic [7:0]  position_q, position_d, pos_cur, pos_inc;
  logic [6:0]  flen_q, flen_d, flen_cur, flen_inc;
  logic [15:0] acc_q, acc_d, acc_cur, acc_f;
  logic        neg_q, neg_d, neg_cur, neg_f;
  logic [15:0] wval_q, wval_d, wval_cur;
  logic [15:0] hval_q, hval_d, hval_cur;

  logic        in_fire;
  logic        is_digit, is_blank;
  logic [19:0] acc_mul10, acc_sum;
  logic [15:0] acc_next_digit;
  logic [15:0] num_val;

  logic        res_emit;
  logic [2:0]  res_status;
  logic [15:0] res_width, res_height, res_gray;
  logic [7:0]  res_len;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [15:0] width_q, height_q, gray_q;
  logic [7:0]  len_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign phase_cur = start_new_i ? PH_P : phase_q;
  assign pos_cur   = start_new_i ? 8'd0 : position_q;
  assign flen_cur  = start_new_i ? 7'd0 : flen_q;
  assign acc_cur   = start_new_i ? 16'd0 : acc_q;
  assign neg_cur   = start_new_i ? 1'b0 : neg_q;
  assign ns_cur    = start_new_i ? NS_BLANKS : ns_q;
  assign wval_cur  = start_new_i ? 16'd0 : wval_q;
  assign hval_cur  = start_new_i ? 16'd0 : hval_q;

  assign pos_inc  = pos_cur + 8'd1;
  assign flen_inc = flen_cur + 7'd1;

  assign is_digit = (header_byte_i >= CH_ZERO) && (header_byte_i <= CH_NINE);
  assign is_blank = (header_byte_i == CH_SPACE) ||
                    ((header_byte_i >= CH_TAB) && (header_byte_i <= CH_CR));

  assign acc_mul10 = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0};
  assign acc_sum   = acc_mul10 + {16'd0, header_byte_i[3:0]};
  assign acc_next_digit = (acc_sum[19:16] != 4'd0) ? VALUE_MAX : acc_sum[15:0];

  assign num_val = neg_cur ? 16'd0 : acc_cur;

  always_comb begin
    acc_f = acc_cur;
    neg_f = neg_cur;
    ns_f  = ns_cur;
    unique case (ns_cur)
      NS_BLANKS: begin
        if (!is_blank) begin
          if ((header_byte_i == CH_PLUS) || (header_byte_i == CH_MINUS)) begin
            neg_f = (header_byte_i == CH_MINUS);
            ns_f  = NS_SIGN;
          end else if (is_digit) begin
            acc_f = {12'd0, header_byte_i[3:0]};
            ns_f  = NS_DIGITS;
          end else begin
            ns_f = NS_DONE;
          end
        end
      end
      NS_SIGN: begin
        if (is_digit) begin
          acc_f = {12'd0, header_byte_i[3:0]};
          ns_f  = NS_DIGITS;
        end else begin
          ns_f = NS_DONE;
        end
      end
      NS_DIGITS: begin
        if (is_digit) begin
          acc_f = acc_next_digit;
        end else begin
          ns_f = NS_DONE;
        end
      end
      NS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Next state of the parser.
  always_comb begin
    phase_d    = phase_q;
    position_d = position_q;
    flen_d     = flen_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    ns_d       = ns_q;
    wval_d     = wval_q;
    hval_d     = hval_q;
    if (in_fire) begin
      phase_d    = phase_cur;
      position_d = pos_cur;
      flen_d     = flen_cur;
      acc_d      = acc_cur;
      neg_d      = neg_cur;
      ns_d       = ns_cur;
      wval_d     = wval_cur;
      hval_d     = hval_cur;
      if (phase_cur != PH_IDLE) begin
        position_d = pos_inc;
      end
      unique case (phase_cur)
        PH_IDLE: begin
        end
        PH_P: begin
          phase_d = (header_byte_i == CH_P) ? PH_FIVE : PH_IDLE;
        end
        PH_FIVE: begin
          phase_d = (header_byte_i == CH_FIVE) ? PH_LF : PH_IDLE;
        end
        PH_LF: begin
          phase_d = (header_byte_i == CH_LF) ? PH_COMMENT : PH_IDLE;
        end
        PH_COMMENT: begin
          if (pos_inc > COMMENT_LIMIT) begin
            phase_d = PH_IDLE;
          end else if (header_byte_i == CH_LF) begin
            phase_d = PH_WIDTH;
            flen_d  = 7'd0;
            acc_d   = 16'd0;
            neg_d   = 1'b0;
            ns_d    = NS_BLANKS;
          end
        end
        PH_WIDTH: begin
          flen_d = flen_inc;
          if (flen_inc > WIDTH_LIMIT) begin
            phase_d = PH_IDLE;
          end else if (header_byte_i == CH_SPACE) begin
            wval_d  = num_val;
            phase_d = PH_HEIGHT;
            flen_d  = 7'd0;
            acc_d   = 16'd0;
            neg_d   = 1'b0;
            ns_d    = NS_BLANKS;
          end else begin
            acc_d = acc_f;
            neg_d = neg_f;
            ns_d  = ns_f;
          end
        end
        PH_HEIGHT: begin
          flen_d = flen_inc;
          if (flen_inc > HEIGHT_LIMIT) begin
            phase_d = PH_IDLE;
          end else if (header_byte_i == CH_LF) begin
            hval_d  = num_val;
            phase_d = PH_GRAY;
            flen_d  = 7'd0;
            acc_d   = 16'd0;
            neg_d   = 1'b0;
            ns_d    = NS_BLANKS;
          end else begin
            acc_d = acc_f;
            neg_d = neg_f;
            ns_d  = ns_f;
          end
        end
        PH_GRAY: begin
          flen_d = flen_inc;
          if ((flen_inc > GRAY_LIMIT) || (header_byte_i == CH_LF)) begin
            phase_d = PH_IDLE;
          end else begin
            acc_d = acc_f;
            neg_d = neg_f;
            ns_d  = ns_f;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result produced by the current byte.
  always_comb begin
    res_emit   = 1'b0;
    res_status = ST_OK;
    res_width  = 16'd0;
    res_height = 16'd0;
    res_gray   = 16'd0;
    res_len    = 8'd0;
    unique case (phase_cur)
      PH_IDLE: begin
      end
      PH_P: begin
        res_emit   = (header_byte_i != CH_P);
        res_status = ST_NO_P;
      end
      PH_FIVE: begin
        res_emit   = (header_byte_i != CH_FIVE);
        res_status = ST_NO_FIVE;
      end
      PH_LF: begin
        res_emit   = (header_byte_i != CH_LF);
        res_status = ST_NO_LF;
      end
      PH_COMMENT: begin
        res_emit   = (pos_inc > COMMENT_LIMIT);
        res_status = ST_COMMENT_LONG;
      end
      PH_WIDTH: begin
        res_emit   = (flen_inc > WIDTH_LIMIT);
        res_status = ST_WIDTH_LONG;
      end
      PH_HEIGHT: begin
        res_emit   = (flen_inc > HEIGHT_LIMIT);
        res_status = ST_HEIGHT_LONG;
      end
      PH_GRAY: begin
        if (flen_inc > GRAY_LIMIT) begin
          res_emit   = 1'b1;
          res_status = ST_GRAY_LONG;
        end else if (header_byte_i == CH_LF) begin
          res_emit   = 1'b1;
          res_status = ST_OK;
          res_width  = wval_cur;
          res_height = hval_cur;
          res_gray   = num_val;
          res_len    = pos_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = (in_fire && res_emit) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      position_q  <= 8'd0;
      flen_q      <= 7'd0;
      acc_q       <= 16'd0;
      neg_q       <= 1'b0;
      ns_q        <= NS_BLANKS;
      wval_q      <= 16'd0;
      hval_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      position_q  <= position_d;
      flen_q      <= flen_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      ns_q        <= ns_d;
      wval_q      <= wval_d;
      hval_q      <= hval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_emit) begin
      status_q <= res_status;
      width_q  <= res_width;
      height_q <= res_height;
      gray_q   <= res_gray;
      len_q    <= res_len;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign width_o            = width_q;
  assign height_o           = height_q;
  assign gray_max_o         = gray_q;
  assign hdr_len_o          = len_q;
  assign data_word_offset_o = len_q[7:2];
  assign data_byte_offset_o = len_q[1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/pgm_hp_checker.sv
`default_nettype none

module pgm_hp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [15:0] width_o,
  input logic [15:0] height_o,
  input logic [15:0] gray_max_o,
  input logic [7:0]  hdr_len_o,
  input logic [5:0]  data_word_offset_o,
  input logic [1:0]  data_byte_offset_o
);
  import pgm_hp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("A stalled result was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(hdr_len_o))
    else $error("A stalled result changed.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (width_o == 16'd0) && (height_o == 16'd0) && (gray_max_o == 16'd0) &&
      (hdr_len_o == 8'd0))
    else $error("An error result carries nonzero fields.");

  a_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (data_word_offset_o == hdr_len_o[7:2]) &&
      (data_byte_offset_o == hdr_len_o[1:0]))
    else $error("Data offsets do not match the header length.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a waiting result.");

endmodule

bind pgm_header_parser_core pgm_hp_checker u_pgm_hp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_o           (status_o),
  .width_o            (width_o),
  .height_o           (height_o),
  .gray_max_o         (gray_max_o),
  .hdr_len_o          (hdr_len_o),
  .data_word_offset_o (data_word_offset_o),
  .data_byte_offset_o (data_byte_offset_o)
);

`default_nettype wire

FILE: tb/sv/pgm_header_checker.sv
`timescale 1ns / 100ps

module pgm_header_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_stall_i,
  input  logic [7:0]  header_byte_i,
  input  logic        start_new_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  input  logic [15:0] gray_max_i,
  input  logic [7:0]  hdr_len_i,
  input  logic [5:0]  data_word_offset_i,
  input  logic [1:0]  data_byte_offset_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  import pgm_hp_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] gray_max;
    logic [7:0]  length;
    logic [5:0]  word_off;
    logic [1:0]  byte_off;
  } hdr_result_t;

  hdr_result_t parsed_headers_q[$];
  hdr_result_t due;

  phase_e      phase;
  logic [7:0]  pos;
  logic [6:0]  fld_len;
  int unsigned accum;
  logic        neg;
  num_state_e  nstate;
  logic [15:0] w_val;
  logic [15:0] h_val;

  initial begin
    mismatches_o = 0;
    outstanding_o = 0;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [15:0] field_value();
    return neg ? 16'd0 : accum[15:0];
  endfunction

  task automatic field_restart();
    fld_len = '0;
    accum = 0;
    neg = 1'b0;
    nstate = NS_BLANKS;
  endtask

  task automatic post_result(input logic [2:0] st, input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] g, input logic [7:0] len);
    hdr_result_t r;
    r.status = st;
    r.width = w;
    r.height = h;
    r.gray_max = g;
    r.length = len;
    r.word_off = len[7:2];
    r.byte_off = len[1:0];
    parsed_headers_q.push_back(r);
    phase = PH_IDLE;
  endtask

  task automatic feed_number(input logic [7:0] b);
    logic digit;
    digit = b >= CH_ZERO && b <= CH_NINE;
    case (nstate)
      NS_BLANKS: begin
        if (!is_blank(b)) begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            neg = (b == CH_MINUS);
            nstate = NS_SIGN;
          end else if (digit) begin
            accum = b - CH_ZERO;
            nstate = NS_DIGITS;
          end else begin
            nstate = NS_DONE;
          end
        end
      end
      NS_SIGN: begin
        if (digit) begin
          accum = b - CH_ZERO;
          nstate = NS_DIGITS;
        end else begin
          nstate = NS_DONE;
        end
      end
      NS_DIGITS: begin
        if (digit) begin
          accum = accum * 10 + (b - CH_ZERO);
          if (accum > VALUE_MAX) begin
            accum = VALUE_MAX;
          end
        end else begin
          nstate = NS_DONE;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic parse_header_byte(input logic [7:0] b, input logic s);
    if (s) begin
      phase = PH_P;
      pos = '0;
      field_restart();
      w_val = '0;
      h_val = '0;
    end
    if (phase != PH_IDLE) begin
      pos = pos + 8'd1;
      case (phase)
        PH_P: begin
          if (b != CH_P) post_result(ST_NO_P, '0, '0, '0, '0);
          else phase = PH_FIVE;
        end
        PH_FIVE: begin
          if (b != CH_FIVE) post_result(ST_NO_FIVE, '0, '0, '0, '0);
          else phase = PH_LF;
        end
        PH_LF: begin
          if (b != CH_LF) post_result(ST_NO_LF, '0, '0, '0, '0);
          else phase = PH_COMMENT;
        end
        PH_COMMENT: begin
          if (pos > COMMENT_LIMIT) begin
            post_result(ST_COMMENT_LONG, '0, '0, '0, '0);
          end else if (b == CH_LF) begin
            phase = PH_WIDTH;
            field_restart();
          end
        end
        PH_WIDTH: begin
          fld_len = fld_len + 7'd1;
          if (fld_len > WIDTH_LIMIT) begin
            post_result(ST_WIDTH_LONG, '0, '0, '0, '0);
          end else if (b == CH_SPACE) begin
            w_val = field_value();
            phase = PH_HEIGHT;
            field_restart();
          end else begin
            feed_number(b);
          end
        end
        PH_HEIGHT: begin
          fld_len = fld_len + 7'd1;
          if (fld_len > HEIGHT_LIMIT) begin
            post_result(ST_HEIGHT_LONG, '0, '0, '0, '0);
          end else if (b == CH_LF) begin
            h_val = field_value();
            phase = PH_GRAY;
            field_restart();
          end else begin
            feed_number(b);
          end
        end
        PH_GRAY: begin
          fld_len = fld_len + 7'd1;
          if (fld_len > GRAY_LIMIT) begin
            post_result(ST_GRAY_LONG, '0, '0, '0, '0);
          end else if (b == CH_LF) begin
            post_result(ST_OK, w_val, h_val, field_value(), pos);
          end else begin
            feed_number(b);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase = PH_IDLE;
      pos = '0;
      field_restart();
      w_val = '0;
      h_val = '0;
      parsed_headers_q.delete();
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (parsed_headers_q.size() == 0) begin
          $error("status: expected no transfer, got %0d", status_i);
          mismatches_o++;
        end else begin
          due = parsed_headers_q.pop_front();
          check_field("status", 16'(due.status), 16'(status_i));
          check_field("width", due.width, width_i);
          check_field("height", due.height, height_i);
          check_field("gray_max", due.gray_max, gray_max_i);
          check_field("hdr_len", 16'(due.length), 16'(hdr_len_i));
          check_field("data_word_offset", 16'(due.word_off), 16'(data_word_offset_i));
          check_field("data_byte_offset", 16'(due.byte_off), 16'(data_byte_offset_i));
        end
      end
      if (byte_valid_i && !byte_stall_i) begin
        parse_header_byte(header_byte_i, start_new_i);
      end
    end
    outstanding_o = parsed_headers_q.size();
  end

endmodule

FILE: tb/sv/tb_pgm_header_parser_core.sv
`timescale 1ns / 100ps

module tb_pgm_header_parser_core;
  import pgm_hp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  header_byte_i = '0;
  logic        start_new_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [15:0] width_o;
  logic [15:0] height_o;
  logic [15:0] gray_max_o;
  logic [7:0]  hdr_len_o;
  logic [5:0]  data_word_offset_o;
  logic [1:0]  data_byte_offset_o;

  int   mismatches;
  int   outstanding;
  int   sent = 0;
  logic bursty = 1'b1;
  logic squeeze_go = 1'b0;
  logic squeeze_done = 1'b0;
  logic [7:0] hdr_q[$];

  pgm_header_parser_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .header_byte_i      (header_byte_i),
    .start_new_i        (start_new_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .width_o            (width_o),
    .height_o           (height_o),
    .gray_max_o         (gray_max_o),
    .hdr_len_o          (hdr_len_o),
    .data_word_offset_o (data_word_offset_o),
    .data_byte_offset_o (data_byte_offset_o)
  );

  pgm_header_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .byte_valid_i       (in_valid_i),
    .byte_stall_i       (in_stall_o),
    .header_byte_i      (header_byte_i),
    .start_new_i        (start_new_i),
    .res_valid_i        (out_valid_o),
    .res_stall_i        (out_stall_i),
    .status_i           (status_o),
    .width_i            (width_o),
    .height_i           (height_o),
    .gray_max_i         (gray_max_o),
    .hdr_len_i          (hdr_len_o),
    .data_word_offset_i (data_word_offset_o),
    .data_byte_offset_i (data_byte_offset_o),
    .mismatches_o       (mismatches),
    .outstanding_o      (outstanding)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] other_than(input logic [7:0] term);
    logic [7:0] b;
    do b = 8'($urandom); while (b == term);
    return b;
  endfunction

  // The stall seen at the falling edge is the one that decides the next rising edge.
  task automatic send_item(input logic [7:0] b, input logic s);
    logic stalled;
    if (bursty && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    header_byte_i <= b;
    start_new_i <= s;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
  endtask

  task automatic send_header();
    foreach (hdr_q[i]) begin
      send_item(hdr_q[i], i == 0);
      sent++;
    end
  endtask

  // Blanks, an optional sign, digits and trailing junk, or now and then a field
  // that runs close to or past its length limit.
  task automatic add_field(input logic [7:0] term, input int limit);
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(limit - 3, limit + 3)) begin
        if ($urandom_range(0, 2) == 0) hdr_q.push_back(other_than(term));
        else hdr_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
    end else begin
      repeat ($urandom_range(0, 2)) begin
        do begin
          b = ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
        end while (b == term);
        hdr_q.push_back(b);
      end
      case ($urandom_range(0, 5))
        0: hdr_q.push_back(CH_PLUS);
        1: hdr_q.push_back(CH_MINUS);
        default: begin
        end
      endcase
      repeat ($urandom_range(0, 7)) hdr_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) hdr_q.push_back(other_than(term));
      end
    end
    hdr_q.push_back(term);
  endtask

  initial begin
    @(posedge clk_i);
    forever begin
      if (squeeze_go && !squeeze_done) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        squeeze_done = 1'b1;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ignored while idle, then each early error, a dropped header and a full one
    // with a negative width, a saturated height and a gray value with no digits.
    send_item(8'hFF, 1'b0);
    hdr_q = {8'h00};
    send_header();
    hdr_q = {CH_P, 8'hFF};
    send_header();
    hdr_q = {CH_P, CH_FIVE, CH_CR};
    send_header();
    hdr_q = {CH_P};
    send_header();
    hdr_q = {CH_P, CH_FIVE, CH_LF, CH_LF, CH_MINUS, 8'h37, CH_SPACE,
             8'h39, 8'h39, 8'h39, 8'h39, 8'h39, CH_LF, CH_PLUS, CH_LF};
    send_header();

    while (sent < 950) begin
      if (sent > 800) bursty = 1'b0;
      if (sent > 300 && !squeeze_go) begin
        squeeze_go = 1'b1;
        repeat (40) begin
          hdr_q = {8'($urandom_range(0, CH_P - 1))};
          send_header();
        end
      end
      hdr_q = {CH_P, CH_FIVE, CH_LF};
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 32) : $urandom_range(0, 6);
      repeat (k) hdr_q.push_back(other_than(CH_LF));
      hdr_q.push_back(CH_LF);
      add_field(CH_SPACE, WIDTH_LIMIT);
      add_field(CH_LF, HEIGHT_LIMIT);
      add_field(CH_LF, GRAY_LIMIT);
      k = $urandom_range(0, 9);
      if (k == 0) begin
        hdr_q[$urandom_range(0, hdr_q.size() - 1)] = 8'($urandom);
      end else if (k == 1) begin
        k = $urandom_range(1, hdr_q.size() - 1);
        while (hdr_q.size() > k) void'(hdr_q.pop_back());
      end
      send_header();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) send_item(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
    in_valid_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
